// ----- sv/mmr_pkg.sv -----
package mmr_pkg;

  // Action codes on the result channel
  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_PLAY     = 3'd1,
    ACT_STOP     = 3'd2,
    ACT_TRIGGER  = 3'd3,
    ACT_PATCH    = 3'd4,
    ACT_BUS      = 3'd5,
    ACT_ENV_LOOP = 3'd6
  } action_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_RX_CHANNEL = 2'd0;
  localparam logic [1:0] CFG_SLOT_NOTES = 2'd1;
  localparam logic [1:0] CFG_POT_CCS    = 2'd2;

  localparam int CFG_DATA_W   = 56;
  localparam int SLOT_TABLE_W = 56;
  localparam int POT_TABLE_W  = 49;
  localparam int MAX_SLOTS    = 8;
  localparam int MAX_POTS     = 7;

  // Message type nibbles and system status bytes
  localparam logic [3:0] TYPE_SYSTEM  = 4'hF;
  localparam logic [3:0] TYPE_NOTE_ON = 4'h9;
  localparam logic [3:0] TYPE_CC      = 4'hB;
  localparam logic [7:0] ST_START     = 8'hFA;
  localparam logic [7:0] ST_CONTINUE  = 8'hFB;
  localparam logic [7:0] ST_STOP      = 8'hFC;

  // Player states
  localparam logic [1:0] PS_STOPPED = 2'd0;
  localparam logic [1:0] PS_ARMED   = 2'd1;

  // Fixed controller numbers
  localparam logic [6:0] CC_MOD_WHEEL = 7'd1;
  localparam logic [6:0] CC_CUTOFF    = 7'd74;
  localparam logic [6:0] CC_ENV_LOOP  = 7'd80;
  localparam logic [6:0] CC_REVERB    = 7'd91;
  localparam logic [6:0] CC_CHORUS    = 7'd93;
  localparam logic [6:0] CC_HALF      = 7'd64;

  // Parameter codes
  localparam logic [3:0] PRM_FILTER  = 4'd5;
  localparam logic [3:0] PRM_BEATDIV = 4'd7;
  localparam logic [3:0] PRM_REVERB  = 4'd8;
  localparam logic [3:0] PRM_CHORUS  = 4'd9;

  // Registered input request
  typedef struct packed {
    logic [7:0]  status;
    logic [6:0]  d1;
    logic [6:0]  d2;
    logic [1:0]  pstate;
    logic [31:0] tick;
  } req_t;

  // Routing decision
  typedef struct packed {
    action_t    action;
    logic [2:0] slot;
    logic [3:0] param;
    logic [6:0] value;
  } route_t;

  // Configuration state
  typedef struct packed {
    logic [4:0]              rx_chan;
    logic [SLOT_TABLE_W-1:0] slot_notes;
    logic [POT_TABLE_W-1:0]  pot_ccs;
  } cfg_t;

endpackage

// ----- sv/mmr_cfg_regs.sv -----
module mmr_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [1:0]                    wr_index,
  input  logic [mmr_pkg::CFG_DATA_W-1:0] wr_data,
  output mmr_pkg::cfg_t                 cfg
);

  mmr_pkg::cfg_t cfg_r, cfg_nxt;

  // Register write decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        mmr_pkg::CFG_RX_CHANNEL: cfg_nxt.rx_chan = wr_data[4:0];
        mmr_pkg::CFG_SLOT_NOTES:
          cfg_nxt.slot_notes = wr_data[mmr_pkg::SLOT_TABLE_W-1:0];
        mmr_pkg::CFG_POT_CCS:
          cfg_nxt.pot_ccs = wr_data[mmr_pkg::POT_TABLE_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- sv/mmr_route.sv -----
module mmr_route #(
  parameter int SLOT_COUNT = 8,
  parameter int POT_COUNT  = 7
) (
  input  mmr_pkg::req_t   req,
  input  mmr_pkg::cfg_t   cfg,
  output mmr_pkg::route_t res
);

  logic       slot_hit;
  logic [2:0] slot_sel;
  logic       pot_hit;
  logic [2:0] pot_sel;
  logic       chan_ok;
  logic [4:0] msg_chan;

  // Lowest matching slot
  always_comb begin
    slot_hit = 1'b0;
    slot_sel = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (cfg.slot_notes[7*i +: 7] == req.d1) begin
        slot_hit = 1'b1;
        slot_sel = 3'(i);
      end
    end
  end

  // Lowest matching pot; a zero entry is unused
  always_comb begin
    pot_hit = 1'b0;
    pot_sel = '0;
    for (int i = POT_COUNT - 1; i >= 0; i--) begin
      if (cfg.pot_ccs[7*i +: 7] != 7'd0 && cfg.pot_ccs[7*i +: 7] == req.d1) begin
        pot_hit = 1'b1;
        pot_sel = 3'(i);
      end
    end
  end

  // Channel filter, zero register means omni
  assign msg_chan = {1'b0, req.status[3:0]} + 5'd1;
  assign chan_ok  = (cfg.rx_chan == 5'd0) || (cfg.rx_chan == msg_chan);

  // Action decision
  always_comb begin
    res = '{action: mmr_pkg::ACT_NONE, slot: '0, param: '0, value: '0};
    if (req.status[7:4] == mmr_pkg::TYPE_SYSTEM) begin
      case (req.status)
        mmr_pkg::ST_START:
          if (req.pstate == mmr_pkg::PS_STOPPED || req.pstate == mmr_pkg::PS_ARMED)
            res.action = mmr_pkg::ACT_PLAY;
        mmr_pkg::ST_CONTINUE:
          if (req.pstate == mmr_pkg::PS_STOPPED) res.action = mmr_pkg::ACT_PLAY;
        mmr_pkg::ST_STOP: res.action = mmr_pkg::ACT_STOP;
        default: res.action = mmr_pkg::ACT_NONE;
      endcase
    end else if (chan_ok) begin
      case (req.status[7:4])
        mmr_pkg::TYPE_NOTE_ON: begin
          if (req.d2 != 7'd0 && slot_hit) begin
            res.action = mmr_pkg::ACT_TRIGGER;
            res.slot   = slot_sel;
            res.value  = req.d2;
          end
        end
        mmr_pkg::TYPE_CC: begin
          if (pot_hit) begin
            res.action = mmr_pkg::ACT_PATCH;
            res.param  = {1'b0, pot_sel};
            res.value  = req.d2;
          end else begin
            case (req.d1)
              mmr_pkg::CC_CUTOFF: begin
                res.action = mmr_pkg::ACT_PATCH;
                res.param  = mmr_pkg::PRM_FILTER;
                res.value  = req.d2;
              end
              mmr_pkg::CC_MOD_WHEEL: begin
                res.action = mmr_pkg::ACT_PATCH;
                res.param  = mmr_pkg::PRM_BEATDIV;
                res.value  = req.d2;
              end
              mmr_pkg::CC_REVERB: begin
                res.action = mmr_pkg::ACT_BUS;
                res.param  = mmr_pkg::PRM_REVERB;
                res.value  = req.d2;
              end
              mmr_pkg::CC_CHORUS: begin
                res.action = mmr_pkg::ACT_BUS;
                res.param  = mmr_pkg::PRM_CHORUS;
                res.value  = req.d2;
              end
              mmr_pkg::CC_ENV_LOOP:
                if (req.d2 >= mmr_pkg::CC_HALF) res.action = mmr_pkg::ACT_ENV_LOOP;
              default: res.action = mmr_pkg::ACT_NONE;
            endcase
          end
        end
        default: res.action = mmr_pkg::ACT_NONE;
      endcase
    end
  end

endmodule

// ----- sv/midi_message_router_top.sv -----
// MIDI message router.
// Input channel: present a decoded message (status, two data bytes), the
// player state and a tick stamp with start high; the request is taken at any
// edge where start is high and busy is low. busy stays low, so a new
// request can be taken every clock.
// Result channel: exactly one result per request, shown for one cycle with
// out_valid high: action, slot index, parameter code, 7-bit value code and
// the tick stamp (zero when the action is none).
// The request passes one input register, the routing compare logic and one
// result register before it is shown.
// Throughput is one request per cycle; the slot and pot table compares run
// in parallel in a single stage.
// Configuration: cfg_valid/cfg_ready write channel, cfg_ready always high.
// Index 0 receive channel, 1 slot note table, 2 pot CC table; others ignored.
// Write only while no request is in flight.
// Reset (synchronous, rst_n low) clears the valid flags and the configuration.
// The receiver cannot stall; results are never held.
module midi_message_router_top #(
  parameter int SLOT_COUNT = 8,
  parameter int POT_COUNT  = 7
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [7:0]                     in_status_byte,
  input  logic [6:0]                     in_first_data,
  input  logic [6:0]                     in_second_data,
  input  logic [1:0]                     in_player_state,
  input  logic [31:0]                    in_tick_stamp,
  output logic                           out_valid,
  output logic [2:0]                     out_action,
  output logic [2:0]                     out_slot_index,
  output logic [3:0]                     out_param_code,
  output logic [6:0]                     out_value_code,
  output logic [31:0]                    out_event_tick,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [mmr_pkg::CFG_DATA_W-1:0] cfg_data
);

  mmr_pkg::cfg_t   cfg;
  mmr_pkg::req_t   req_r, req_nxt;
  logic            req_vld_r;
  mmr_pkg::route_t route;
  mmr_pkg::route_t res_r;
  logic [31:0]     tick_r, tick_nxt;
  logic            res_vld_r;
  logic            accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  mmr_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Input register
  assign req_nxt = '{status: in_status_byte, d1: in_first_data, d2: in_second_data,
                     pstate: in_player_state, tick: in_tick_stamp};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else begin
      req_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= req_nxt;
    end
  end

  mmr_route #(
    .SLOT_COUNT (SLOT_COUNT),
    .POT_COUNT  (POT_COUNT)
  ) u_route (
    .req (req_r),
    .cfg (cfg),
    .res (route)
  );

  // Result register; tick only reported with a real action
  assign tick_nxt = (route.action == mmr_pkg::ACT_NONE) ? 32'd0 : req_r.tick;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= req_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req_vld_r) begin
      res_r  <= route;
      tick_r <= tick_nxt;
    end
  end

  assign out_valid      = res_vld_r;
  assign out_action     = res_r.action;
  assign out_slot_index = res_r.slot;
  assign out_param_code = res_r.param;
  assign out_value_code = res_r.value;
  assign out_event_tick = tick_r;

  // Every accepted request yields a result through the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##2 out_valid)
    else $error("result missing two cycles after request");

  // No result without an earlier accepted request
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 2))
    else $error("result without request");

  // Tick is zero for a no-op action
  a_tick_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action == mmr_pkg::ACT_NONE) |-> out_event_tick == 32'd0)
    else $error("tick set on none action");

  // Slot index only carried by a trigger
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action != mmr_pkg::ACT_TRIGGER) |-> out_slot_index == 3'd0)
    else $error("slot index set without trigger");

  // Parameter code only carried by param actions
  a_param_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action != mmr_pkg::ACT_PATCH && out_action != mmr_pkg::ACT_BUS)
      |-> out_param_code == 4'd0)
    else $error("param code set without param action");

endmodule

// ----- test/testbench.sv -----
module testbench;

  // Codes the package does not name
  localparam logic [1:0] CFG_UNUSED    = 2'd3;
  localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
  localparam logic [3:0] TYPE_PITCH    = 4'hE;
  localparam logic [7:0] ST_CLOCK      = 8'hF8;
  localparam logic [7:0] ST_RESET      = 8'hFF;
  localparam logic [1:0] PS_PLAYING    = 2'd2;
  localparam logic [1:0] PS_UNDEFINED  = 2'd3;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_ITEMS    = 250;

  typedef struct packed {
    mmr_pkg::action_t action;
    logic [2:0]       slot;
    logic [3:0]       param;
    logic [6:0]       value;
    logic [31:0]      tick;
  } route_result_t;

  // Expected-action scoreboard with its own copy of the routing registers
  class route_scoreboard_t;
    logic [4:0]                       rx_chan;
    logic [mmr_pkg::SLOT_TABLE_W-1:0] slot_notes;
    logic [mmr_pkg::POT_TABLE_W-1:0]  pot_ccs;
    route_result_t                    action_q[$];
    int                               mismatches;
    int                               results_seen;
    int                               action_hits[8];

    function new();
      rx_chan      = '0;
      slot_notes   = '0;
      pot_ccs      = '0;
      mismatches   = 0;
      results_seen = 0;
      foreach (action_hits[i]) action_hits[i] = 0;
    endfunction

    function void apply_config(logic [1:0] idx, logic [mmr_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        mmr_pkg::CFG_RX_CHANNEL: rx_chan = data[4:0];
        mmr_pkg::CFG_SLOT_NOTES: slot_notes = data[mmr_pkg::SLOT_TABLE_W-1:0];
        mmr_pkg::CFG_POT_CCS:    pot_ccs = data[mmr_pkg::POT_TABLE_W-1:0];
        default: ;
      endcase
    endfunction

    function route_result_t route_message(mmr_pkg::req_t r);
      route_result_t e;
      logic [3:0]    kind;
      logic [4:0]    chan;
      bit            pot_hit;
      e       = '0;
      kind    = r.status[7:4];
      chan    = {1'b0, r.status[3:0]} + 5'd1;
      pot_hit = 1'b0;
      if (kind == mmr_pkg::TYPE_SYSTEM) begin
        // Transport messages bypass the channel filter
        if (r.status == mmr_pkg::ST_START &&
            (r.pstate == mmr_pkg::PS_STOPPED || r.pstate == mmr_pkg::PS_ARMED))
          e.action = mmr_pkg::ACT_PLAY;
        else if (r.status == mmr_pkg::ST_CONTINUE && r.pstate == mmr_pkg::PS_STOPPED)
          e.action = mmr_pkg::ACT_PLAY;
        else if (r.status == mmr_pkg::ST_STOP)
          e.action = mmr_pkg::ACT_STOP;
      end else if (rx_chan != '0 && chan != rx_chan) begin
        e.action = mmr_pkg::ACT_NONE;
      end else if (kind == mmr_pkg::TYPE_NOTE_ON) begin
        // Walk down so the lowest matching slot wins
        if (r.d2 != '0) begin
          for (int s = mmr_pkg::MAX_SLOTS - 1; s >= 0; s--) begin
            if (slot_notes[7*s +: 7] == r.d1) begin
              e.action = mmr_pkg::ACT_TRIGGER;
              e.slot   = 3'(s);
              e.value  = r.d2;
            end
          end
        end
      end else if (kind == mmr_pkg::TYPE_CC) begin
        for (int p = mmr_pkg::MAX_POTS - 1; p >= 0; p--) begin
          if (pot_ccs[7*p +: 7] != '0 && pot_ccs[7*p +: 7] == r.d1) begin
            e.action = mmr_pkg::ACT_PATCH;
            e.param  = 4'(p);
            e.value  = r.d2;
            pot_hit  = 1'b1;
          end
        end
        if (!pot_hit) begin
          case (r.d1)
            mmr_pkg::CC_CUTOFF: begin
              e.action = mmr_pkg::ACT_PATCH;
              e.param  = mmr_pkg::PRM_FILTER;
              e.value  = r.d2;
            end
            mmr_pkg::CC_MOD_WHEEL: begin
              e.action = mmr_pkg::ACT_PATCH;
              e.param  = mmr_pkg::PRM_BEATDIV;
              e.value  = r.d2;
            end
            mmr_pkg::CC_REVERB: begin
              e.action = mmr_pkg::ACT_BUS;
              e.param  = mmr_pkg::PRM_REVERB;
              e.value  = r.d2;
            end
            mmr_pkg::CC_CHORUS: begin
              e.action = mmr_pkg::ACT_BUS;
              e.param  = mmr_pkg::PRM_CHORUS;
              e.value  = r.d2;
            end
            mmr_pkg::CC_ENV_LOOP: begin
              if (r.d2 >= mmr_pkg::CC_HALF) e.action = mmr_pkg::ACT_ENV_LOOP;
            end
            default: ;
          endcase
        end
      end
      if (e.action != mmr_pkg::ACT_NONE) e.tick = r.tick;
      return e;
    endfunction

    function void note_request(mmr_pkg::req_t r);
      action_q.push_back(route_message(r));
    endfunction

    function int pending();
      return action_q.size();
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_result(route_result_t got);
      route_result_t want;
      results_seen++;
      action_hits[got.action]++;
      if (action_q.size() == 0) begin
        report($sformatf("result with nothing pending, action %0d", got.action));
        return;
      end
      want = action_q.pop_front();
      if (got.action != want.action)
        report($sformatf("action %0d, want %0d", got.action, want.action));
      if (got.slot != want.slot)
        report($sformatf("slot %0d, want %0d", got.slot, want.slot));
      if (got.param != want.param)
        report($sformatf("param %0d, want %0d", got.param, want.param));
      if (got.value != want.value)
        report($sformatf("value %0d, want %0d", got.value, want.value));
      if (got.tick != want.tick)
        report($sformatf("tick %0h, want %0h", got.tick, want.tick));
    endtask
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic                           busy;
  logic [7:0]                     in_status_byte = '0;
  logic [6:0]                     in_first_data = '0;
  logic [6:0]                     in_second_data = '0;
  logic [1:0]                     in_player_state = '0;
  logic [31:0]                    in_tick_stamp = '0;
  logic                           out_valid;
  logic [2:0]                     out_action;
  logic [2:0]                     out_slot_index;
  logic [3:0]                     out_param_code;
  logic [6:0]                     out_value_code;
  logic [31:0]                    out_event_tick;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [1:0]                     cfg_index = '0;
  logic [mmr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  route_scoreboard_t sb = new();
  int                requests_taken = 0;
  int                reg_writes = 0;
  int                quiet_cycles = 0;

  midi_message_router_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_status_byte  (in_status_byte),
    .in_first_data   (in_first_data),
    .in_second_data  (in_second_data),
    .in_player_state (in_player_state),
    .in_tick_stamp   (in_tick_stamp),
    .out_valid       (out_valid),
    .out_action      (out_action),
    .out_slot_index  (out_slot_index),
    .out_param_code  (out_param_code),
    .out_value_code  (out_value_code),
    .out_event_tick  (out_event_tick),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sample every handshake on the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        sb.note_request({in_status_byte, in_first_data, in_second_data,
                         in_player_state, in_tick_stamp});
        requests_taken++;
      end
      if (out_valid)
        sb.check_result({out_action, out_slot_index, out_param_code,
                         out_value_code, out_event_tick});
      if (cfg_valid && cfg_ready) begin
        sb.apply_config(cfg_index, cfg_data);
        reg_writes++;
      end
    end
  end

  // Watchdog: too long without any handshake
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no handshake for %0d cycles", $time, quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic mmr_pkg::req_t mk(logic [7:0] st, logic [6:0] a, logic [6:0] b,
                                       logic [1:0] ps, logic [31:0] tk);
    return {st, a, b, ps, tk};
  endfunction

  function automatic logic [6:0] fixed_cc();
    case ($urandom_range(0, 4))
      0: return mmr_pkg::CC_CUTOFF;
      1: return mmr_pkg::CC_MOD_WHEEL;
      2: return mmr_pkg::CC_REVERB;
      3: return mmr_pkg::CC_CHORUS;
      default: return mmr_pkg::CC_ENV_LOOP;
    endcase
  endfunction

  // Mostly messages that reach a table or a fixed CC, some pure noise
  function automatic mmr_pkg::req_t random_request();
    mmr_pkg::req_t r;
    logic [3:0]    chan_nib;
    int            pick;
    int            s;
    r.d1     = 7'($urandom);
    r.d2     = 7'($urandom);
    r.pstate = 2'($urandom);
    r.tick   = $urandom;
    if (sb.rx_chan >= 5'd1 && sb.rx_chan <= 5'd16 && $urandom_range(0, 9) < 8)
      chan_nib = 4'(sb.rx_chan - 5'd1);
    else
      chan_nib = 4'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      r.status = {mmr_pkg::TYPE_NOTE_ON, chan_nib};
      if ($urandom_range(0, 9) < 7) begin
        s = $urandom_range(0, mmr_pkg::MAX_SLOTS - 1);
        r.d1 = sb.slot_notes[7*s +: 7];
      end
      if ($urandom_range(0, 6) == 0) r.d2 = '0;
    end else if (pick < 65) begin
      r.status = {mmr_pkg::TYPE_CC, chan_nib};
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          s = $urandom_range(0, mmr_pkg::MAX_POTS - 1);
          r.d1 = sb.pot_ccs[7*s +: 7];
        end
        4, 5, 6: r.d1 = fixed_cc();
        default: ;
      endcase
    end else if (pick < 80) begin
      case ($urandom_range(0, 3))
        0: r.status = mmr_pkg::ST_START;
        1: r.status = mmr_pkg::ST_CONTINUE;
        2: r.status = mmr_pkg::ST_STOP;
        default: r.status = {mmr_pkg::TYPE_SYSTEM, 4'($urandom)};
      endcase
    end else begin
      r.status = 8'($urandom);
    end
    return r;
  endfunction

  // Called at a falling edge; leaves start high on return
  task send_request(mmr_pkg::req_t r, int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start           <= 1'b1;
    in_status_byte  <= r.status;
    in_first_data   <= r.d1;
    in_second_data  <= r.d2;
    in_player_state <= r.pstate;
    in_tick_stamp   <= r.tick;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task write_reg(logic [1:0] idx, logic [mmr_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Stop sending and let the pipeline empty before touching registers
  task settle();
    start <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Upper data bits beyond each register's width carry junk on purpose
  task configure(logic [4:0] rx, logic [mmr_pkg::SLOT_TABLE_W-1:0] notes,
                 logic [mmr_pkg::POT_TABLE_W-1:0] ccs, bit junk_write);
    logic [63:0]                    junk_raw;
    logic [mmr_pkg::CFG_DATA_W-1:0] junk;
    junk_raw = {$urandom, $urandom};
    junk     = junk_raw[mmr_pkg::CFG_DATA_W-1:0];
    write_reg(mmr_pkg::CFG_RX_CHANNEL, {junk[mmr_pkg::CFG_DATA_W-1:5], rx});
    write_reg(mmr_pkg::CFG_SLOT_NOTES, notes);
    write_reg(mmr_pkg::CFG_POT_CCS,
              {junk[mmr_pkg::CFG_DATA_W-1:mmr_pkg::POT_TABLE_W], ccs});
    if (junk_write) write_reg(CFG_UNUSED, junk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [mmr_pkg::SLOT_TABLE_W-1:0] random_slot_notes();
    logic [mmr_pkg::SLOT_TABLE_W-1:0] t;
    t = '0;
    for (int s = 0; s < mmr_pkg::MAX_SLOTS; s++) begin
      if (s > 0 && $urandom_range(0, 3) == 0)
        t[7*s +: 7] = t[7*(s-1) +: 7];
      else
        t[7*s +: 7] = 7'($urandom);
    end
    return t;
  endfunction

  function automatic logic [mmr_pkg::POT_TABLE_W-1:0] random_pot_ccs();
    logic [mmr_pkg::POT_TABLE_W-1:0] t;
    t = '0;
    for (int p = 0; p < mmr_pkg::MAX_POTS; p++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: t[7*p +: 7] = '0;
        3, 4:    t[7*p +: 7] = fixed_cc();
        default: t[7*p +: 7] = 7'($urandom);
      endcase
    end
    return t;
  endfunction

  initial begin
    logic [4:0] rx;
    int         idle_pct;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset tables: omni, every note 0, every pot unused
    send_request(mk({mmr_pkg::TYPE_NOTE_ON, 4'h0}, 7'd0, 7'd127,
                    mmr_pkg::PS_STOPPED, 32'hFFFF_FFFF), 0);
    send_request(mk({mmr_pkg::TYPE_NOTE_ON, 4'h5}, 7'd0, 7'd0,
                    mmr_pkg::PS_ARMED, 32'h1), 0);
    send_request(mk({mmr_pkg::TYPE_NOTE_ON, 4'hF}, 7'd127, 7'd1, PS_PLAYING, 32'h0), 0);
    send_request(mk(mmr_pkg::ST_START, 7'd0, 7'd0, mmr_pkg::PS_STOPPED, 32'h0), 0);
    send_request(mk(mmr_pkg::ST_START, 7'd127, 7'd127,
                    mmr_pkg::PS_ARMED, 32'hFFFF_FFFF), 0);
    send_request(mk(mmr_pkg::ST_START, 7'd0, 7'd0, PS_PLAYING, 32'h1234_5678), 0);
    send_request(mk(mmr_pkg::ST_START, 7'd0, 7'd0, PS_UNDEFINED, 32'h8000_0000), 0);
    send_request(mk(mmr_pkg::ST_CONTINUE, 7'd0, 7'd0,
                    mmr_pkg::PS_STOPPED, 32'h7FFF_FFFF), 0);
    send_request(mk(mmr_pkg::ST_CONTINUE, 7'd0, 7'd0, mmr_pkg::PS_ARMED, 32'h2), 0);
    send_request(mk(mmr_pkg::ST_STOP, 7'd0, 7'd0, PS_PLAYING, 32'hFFFF_FFFF), 0);
    send_request(mk(mmr_pkg::ST_STOP, 7'd0, 7'd0, PS_UNDEFINED, 32'h3), 0);
    send_request(mk(ST_CLOCK, 7'd127, 7'd127, mmr_pkg::PS_STOPPED, 32'h4), 0);
    send_request(mk(ST_RESET, 7'd0, 7'd0, mmr_pkg::PS_STOPPED, 32'h5), 0);
    send_request(mk({mmr_pkg::TYPE_CC, 4'h0}, mmr_pkg::CC_CUTOFF, 7'd127,
                    mmr_pkg::PS_STOPPED, 32'h6), 0);
    send_request(mk({mmr_pkg::TYPE_CC, 4'h3}, mmr_pkg::CC_REVERB, 7'd0,
                    PS_PLAYING, 32'h7), 0);
    send_request(mk({mmr_pkg::TYPE_CC, 4'h9}, mmr_pkg::CC_CHORUS, 7'd64,
                    mmr_pkg::PS_ARMED, 32'h8), 0);
    send_request(mk({mmr_pkg::TYPE_CC, 4'hF}, mmr_pkg::CC_MOD_WHEEL, 7'd5,
                    mmr_pkg::PS_STOPPED, 32'h9), 0);
    send_request(mk({mmr_pkg::TYPE_CC, 4'h1}, mmr_pkg::CC_ENV_LOOP, 7'd64,
                    mmr_pkg::PS_STOPPED, 32'hA), 0);
    send_request(mk({mmr_pkg::TYPE_CC, 4'h1}, mmr_pkg::CC_ENV_LOOP, 7'd63,
                    mmr_pkg::PS_STOPPED, 32'hB), 0);
    send_request(mk({mmr_pkg::TYPE_CC, 4'h2}, 7'd0, 7'd127,
                    mmr_pkg::PS_STOPPED, 32'hC), 0);
    send_request(mk({TYPE_NOTE_OFF, 4'h0}, 7'd0, 7'd100, mmr_pkg::PS_STOPPED, 32'hD), 0);
    send_request(mk({TYPE_PITCH, 4'h3}, 7'd0, 7'd100, mmr_pkg::PS_STOPPED, 32'hE), 0);
    settle();

    // Channel 16, duplicate slot notes, pots shadowing fixed CCs
    configure(5'd16, {7'd0, 7'd0, 7'd60, 7'd0, 7'd60, 7'd0, 7'd0, 7'd127},
              {7'd127, 7'd0, 7'd0, 7'd0, 7'd1, 7'd0, 7'd74}, 1'b1);
    send_request(mk({mmr_pkg::TYPE_NOTE_ON, 4'hF}, 7'd60, 7'd100, PS_PLAYING, 32'hF0), 0);
    send_request(mk({mmr_pkg::TYPE_NOTE_ON, 4'hE}, 7'd60, 7'd100, PS_PLAYING, 32'hF1), 0);
    send_request(mk({mmr_pkg::TYPE_CC, 4'hF}, mmr_pkg::CC_CUTOFF, 7'd33,
                    PS_PLAYING, 32'hF2), 0);
    send_request(mk({mmr_pkg::TYPE_CC, 4'hF}, 7'd127, 7'd127, PS_PLAYING, 32'hF3), 0);
    settle();

    // Channel register past sixteen blocks every channel message
    configure(5'd31, '1, '1, 1'b0);
    send_request(mk({mmr_pkg::TYPE_NOTE_ON, 4'hF}, 7'd127, 7'd100,
                    mmr_pkg::PS_STOPPED, 32'hF4), 0);
    send_request(mk(mmr_pkg::ST_START, 7'd0, 7'd0, mmr_pkg::PS_STOPPED, 32'hF5), 0);
    settle();

    // Random phases: sender idling 24%, then 73%, then back to back
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: rx = 5'd0;
        1: rx = 5'd16;
        2: rx = 5'($urandom_range(1, 16));
        3: rx = 5'($urandom_range(17, 31));
        4: rx = 5'($urandom_range(1, 16));
        default: rx = 5'd1;
      endcase
      if (phase == 2) configure(rx, '1, '1, 1'b1);
      else configure(rx, random_slot_notes(), random_pot_ccs(), 1'b1);
      idle_pct = (phase < 2) ? 24 : (phase < 4) ? 73 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) send_request(random_request(), idle_pct);
      settle();
    end

    // settle() already drained; the extra wait catches stray strobes
    repeat (4) @(negedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("Routed %0d messages, %0d results checked, %0d register writes.",
             requests_taken, sb.results_seen, reg_writes);
    $display("Actions: none %0d play %0d stop %0d trigger %0d patch %0d bus %0d loop %0d",
             sb.action_hits[0], sb.action_hits[1], sb.action_hits[2], sb.action_hits[3],
             sb.action_hits[4], sb.action_hits[5], sb.action_hits[6]);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
